// ----- src/wps_pkg.sv -----
// Shared types and constants of the waveform peak segmenter.
package wps_pkg;

    // Deviation from baseline: 16-bit sample minus 16-bit offset needs 17 bits
    typedef logic signed [16:0] wps_dev_t;

    // Magnitude of a deviation never exceeds 65535
    typedef logic [15:0] wps_mag_t;

    // Width of an output position field
    localparam int OUT_POS_BITS = 16;

    // Samples of a waveform that only fill the history
    localparam int HISTORY_LEN = 3;

    // Classified sample handed from front to back
    typedef struct packed {
        wps_dev_t dev;
        wps_mag_t mag;
        logic     quiet;
        logic     last;
    } wps_item_t;

    // One reported peak
    typedef struct packed {
        logic [OUT_POS_BITS-1:0] start;
        logic [OUT_POS_BITS-1:0] stop;
        logic [15:0]             height;
        logic [OUT_POS_BITS-1:0] max_pos;
        logic                    negative;
    } wps_peak_t;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Configuration register index, taken from paddr[2]
    typedef enum logic {
        REG_BASELINE  = 1'b0,
        REG_THRESHOLD = 1'b1
    } wps_reg_t;

endpackage

// ----- src/wps_front.sv -----
// Front end: configuration registers and per-sample baseline subtraction and noise test.
module wps_front #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    input  logic [15:0]         sample,
    input  logic                sample_last,
    output wps_pkg::wps_item_t  item
);
    import wps_pkg::*;

    logic signed [15:0] baseline_reg;
    logic signed [15:0] baseline_next;
    logic [15:0]        threshold_reg;
    logic [15:0]        threshold_next;
    wps_reg_t           reg_sel;
    logic               wr_en;
    wps_dev_t           sample_ext;
    wps_dev_t           dev;
    logic [16:0]        dev_abs;

    assign reg_sel = wps_reg_t'(paddr[2]);
    assign wr_en   = psel && penable && pwrite;

    always_comb
    begin
        baseline_next  = baseline_reg;
        threshold_next = threshold_reg;
        if (wr_en)
        begin
            unique case (reg_sel)
                REG_BASELINE:  baseline_next  = pwdata[15:0];
                REG_THRESHOLD: threshold_next = pwdata[15:0];
                default:       baseline_next  = baseline_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_BASELINE:  prdata = {{16{baseline_reg[15]}}, baseline_reg};
            REG_THRESHOLD: prdata = {16'h0000, threshold_reg};
            default:       prdata = 32'h0000_0000;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            baseline_reg  <= '0;
            threshold_reg <= '0;
        end
        else
        begin
            baseline_reg  <= baseline_next;
            threshold_reg <= threshold_next;
        end
    end

    // Take the low SAMPLE_BITS bits and sign extend
    assign sample_ext = 17'(signed'(sample[SAMPLE_BITS-1:0]));
    assign dev        = sample_ext - 17'(baseline_reg);
    assign dev_abs    = dev[16] ? 17'(-dev) : 17'(dev);

    assign item.dev   = dev;
    assign item.mag   = dev_abs[15:0];
    assign item.quiet = dev_abs[15:0] <= threshold_reg;
    assign item.last  = sample_last;

endmodule

// ----- src/wps_fifo.sv -----
// Short queue of classified samples between front and back.
module wps_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  wps_pkg::wps_item_t  push_item,
    output logic                full,
    input  logic                pop,
    output logic                empty,
    output wps_pkg::wps_item_t  head_item
);
    import wps_pkg::*;

    wps_item_t           mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg;
    logic [QUEUE_AW:0]   count_next;

    assign full      = count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH);
    assign empty     = count_reg == '0;
    assign head_item = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- src/wps_back.sv -----
// Back end: segment tracking, rising-edge check and the output register.
module wps_back #(
    parameter int POSITION_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  wps_pkg::wps_item_t  item,
    output logic                pop,
    output logic                peak_valid,
    output wps_pkg::wps_peak_t  peak,
    input  logic                peak_ready
);
    import wps_pkg::*;

    logic [POSITION_BITS-1:0] pos_reg;
    logic [POSITION_BITS-1:0] pos_next;
    wps_dev_t                 prev_dev_reg;
    wps_dev_t                 prev_dev_next;
    wps_mag_t                 hist_mag_reg  [HISTORY_LEN];
    wps_mag_t                 hist_mag_next [HISTORY_LEN];
    logic                     rising_reg;
    logic                     rising_next;
    logic                     open_reg;
    logic                     open_next;
    logic [POSITION_BITS-1:0] start_reg;
    logic [POSITION_BITS-1:0] start_next;
    wps_mag_t                 max_reg;
    wps_mag_t                 max_next;
    logic [POSITION_BITS-1:0] max_pos_reg;
    logic [POSITION_BITS-1:0] max_pos_next;
    logic                     max_neg_reg;
    logic                     max_neg_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    wps_peak_t                peak_reg;
    wps_peak_t                peak_next;
    logic                     zero_cross;
    logic                     close;
    logic                     rise;

    // Each word yields at most one peak, so a free output slot is enough
    assign pop        = item_valid && (!out_valid_reg || peak_ready);
    assign peak_valid = out_valid_reg;
    assign peak       = peak_reg;

    assign zero_cross = (!item.dev[16] && item.dev != '0 && prev_dev_reg[16])
                     || (item.dev[16] && !prev_dev_reg[16] && prev_dev_reg != '0);
    assign close = item.quiet || item.last || zero_cross;
    assign rise  = hist_mag_reg[2] < hist_mag_reg[1]
                && hist_mag_reg[1] < hist_mag_reg[0]
                && hist_mag_reg[0] < item.mag;

    always_comb
    begin
        pos_next       = pos_reg;
        prev_dev_next  = prev_dev_reg;
        hist_mag_next  = hist_mag_reg;
        rising_next    = rising_reg;
        open_next      = open_reg;
        start_next     = start_reg;
        max_next       = max_reg;
        max_pos_next   = max_pos_reg;
        max_neg_next   = max_neg_reg;
        out_valid_next = out_valid_reg && !peak_ready;
        peak_next      = peak_reg;

        if (pop)
        begin
            if (pos_reg >= POSITION_BITS'(HISTORY_LEN))
            begin
                if (close)
                begin
                    if (open_reg && rising_reg)
                    begin
                        out_valid_next    = 1'b1;
                        peak_next.start    = OUT_POS_BITS'(start_reg);
                        peak_next.stop     = OUT_POS_BITS'(pos_reg - POSITION_BITS'(1));
                        peak_next.height   = max_reg;
                        peak_next.max_pos  = OUT_POS_BITS'(max_pos_reg);
                        peak_next.negative = max_neg_reg;
                    end
                    rising_next = 1'b0;
                    open_next   = 1'b0;
                end
                else
                begin
                    // Open a segment, or track its first largest deviation
                    if (!open_reg || item.mag > max_reg)
                    begin
                        max_next     = item.mag;
                        max_pos_next = pos_reg;
                        max_neg_next = item.dev[16];
                    end
                    if (!open_reg)
                    begin
                        open_next  = 1'b1;
                        start_next = pos_reg;
                    end
                    if (rise)
                        rising_next = 1'b1;
                end
            end

            prev_dev_next    = item.dev;
            hist_mag_next[0] = item.mag;
            hist_mag_next[1] = hist_mag_reg[0];
            hist_mag_next[2] = hist_mag_reg[1];

            if (item.last)
            begin
                pos_next    = '0;
                open_next   = 1'b0;
                rising_next = 1'b0;
            end
            else if (!(&pos_reg))
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            prev_dev_reg  <= '0;
            hist_mag_reg  <= '{default: '0};
            rising_reg    <= 1'b0;
            open_reg      <= 1'b0;
            start_reg     <= '0;
            max_reg       <= '0;
            max_pos_reg   <= '0;
            max_neg_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            prev_dev_reg  <= prev_dev_next;
            hist_mag_reg  <= hist_mag_next;
            rising_reg    <= rising_next;
            open_reg      <= open_next;
            start_reg     <= start_next;
            max_reg       <= max_next;
            max_pos_reg   <= max_pos_next;
            max_neg_reg   <= max_neg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        peak_reg <= peak_next;
    end

endmodule

// ----- src/waveform_peak_segmenter_unit.sv -----
// Top level of the waveform peak segmenter.
//
// Samples enter on the slave stream (s_tdata = sample, s_tlast = last sample
// of a waveform). Each has the baseline offset subtracted; from the fourth
// sample of a waveform on, samples outside the noise band form a segment,
// which closes on a noise sample, a zero crossing or the last sample. A
// closed segment in which a sample ended a run of four strictly rising
// magnitudes is reported on the master stream as one word.
// Configuration: APB, baseline offset at 0x0, noise threshold at 0x4.
// Throughput: one sample per cycle while s_tready is high. A front stage
// classifies the sample and writes a four-entry queue; the back stage drains
// one entry per cycle, while the output word is free or taken, into the output
// register. A closing sample passes the queue before its peak is registered.
// While m_tready is low the output register holds its word; the back stage
// stops, the queue fills and s_tready falls once it is full.
// Reset clears the configuration registers, the queue and all segment state.
module waveform_peak_segmenter_unit #(
    parameter int SAMPLE_BITS   = 16,
    parameter int POSITION_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [15:0] peak_start, [31:16] peak_stop,
                                   // [47:32] peak_height, [63:48] peak_max_pos
    output logic        m_tuser    // [0] peak_polarity
);
    import wps_pkg::*;

    wps_item_t front_item;
    wps_item_t head_item;
    wps_peak_t peak;
    logic      full;
    logic      empty;
    logic      pop;
    logic      push;

    assign pready   = 1'b1;
    assign s_tready = !full;
    assign push     = s_tvalid && !full;

    wps_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .sample      (s_tdata),
        .sample_last (s_tlast),
        .item        (front_item)
    );

    wps_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .full      (full),
        .pop       (pop),
        .empty     (empty),
        .head_item (head_item)
    );

    wps_back #(
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (!empty),
        .item       (head_item),
        .pop        (pop),
        .peak_valid (m_tvalid),
        .peak       (peak),
        .peak_ready (m_tready)
    );

    assign m_tdata = {peak.max_pos, peak.height, peak.stop, peak.start};
    assign m_tuser = peak.negative;

endmodule

// ----- src/wps_checker.sv -----
// Port-level checks of the waveform peak segmenter, bound to the top level.
module wps_checker #(
    parameter int POSITION_BITS = 16
) (
    input logic        clk,
    input logic        rst_n,
    input logic        pready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tuser
);

    // Hold a stalled word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled output word changed");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped");

    // A segment sample is never inside the noise band, so height is nonzero
    a_height: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[47:32] != 16'h0000)
        else $error("peak height of zero");

    // Peak position never precedes the segment start while positions fit the field
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && POSITION_BITS <= 16 |-> m_tdata[15:0] <= m_tdata[63:48])
        else $error("peak position before segment start");

endmodule

bind waveform_peak_segmenter_unit wps_checker #(
    .POSITION_BITS (POSITION_BITS)
) u_wps_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .pready   (pready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the waveform peak segmenter: streams waveforms and checks every peak.
module testbench;
    import wps_pkg::*;

    localparam int          STALL_LIMIT  = 2000;
    localparam int          DRAIN_CYCLES = 12;
    localparam logic [15:0] POS_TOP      = 16'hFFFF;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // [15:0] sample
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;         // [15:0] start, [31:16] stop, [47:32] height, [63:48] max_pos
    logic        m_tuser;         // [0] polarity

    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    int mismatch_count  = 0;
    int samples_sent    = 0;

    wps_peak_t pending_peaks[$];

    // Own copy of the configuration and the segment state
    logic signed [15:0] cfg_baseline  = '0;
    logic [15:0]        cfg_threshold = '0;
    wps_dev_t           dev_hist[3]   = '{default: '0};
    logic [15:0]        sample_pos    = '0;
    logic               seg_open      = 1'b0;
    logic               seg_rising    = 1'b0;
    logic [15:0]        seg_start     = '0;
    wps_mag_t           seg_max       = '0;
    logic [15:0]        seg_max_pos   = '0;
    logic               seg_max_neg   = 1'b0;

    waveform_peak_segmenter_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic wps_mag_t mag_of(input wps_dev_t d);
        wps_dev_t neg;
        neg = -d;
        return d[16] ? neg[15:0] : d[15:0];
    endfunction

    function automatic int noise_dev();
        int span;
        span = (cfg_threshold > 16'd2000) ? 2000 : int'(cfg_threshold);
        return $urandom_range(1) ? int'($urandom_range(0, span)) : -int'($urandom_range(0, span));
    endfunction

    // Advance the segment state by one accepted sample; queue the peak it closes, if any
    task automatic predict_peak(input logic [15:0] smp, input logic lst);
        wps_dev_t  dev;
        wps_mag_t  m;
        logic      crossing;
        wps_peak_t pk;
        dev = {smp[15], smp} - {cfg_baseline[15], cfg_baseline};
        m   = mag_of(dev);
        if (sample_pos >= HISTORY_LEN)
        begin
            crossing = (dev != 0) && (dev_hist[0] != 0) && (dev[16] != dev_hist[0][16]);
            if (m <= cfg_threshold || lst || crossing)
            begin
                if (seg_open && seg_rising)
                begin
                    pk.start    = seg_start;
                    pk.stop     = sample_pos - 16'd1;
                    pk.height   = seg_max;
                    pk.max_pos  = seg_max_pos;
                    pk.negative = seg_max_neg;
                    pending_peaks = {pending_peaks, pk};
                end
                seg_open   = 1'b0;
                seg_rising = 1'b0;
            end
            else
            begin
                if (!seg_open)
                begin
                    seg_open    = 1'b1;
                    seg_start   = sample_pos;
                    seg_max     = m;
                    seg_max_pos = sample_pos;
                    seg_max_neg = dev[16];
                end
                else if (m > seg_max)
                begin
                    seg_max     = m;
                    seg_max_pos = sample_pos;
                    seg_max_neg = dev[16];
                end
                if (!seg_rising && mag_of(dev_hist[2]) < mag_of(dev_hist[1]) &&
                    mag_of(dev_hist[1]) < mag_of(dev_hist[0]) && mag_of(dev_hist[0]) < m)
                    seg_rising = 1'b1;
            end
        end
        dev_hist[2] = dev_hist[1];
        dev_hist[1] = dev_hist[0];
        dev_hist[0] = dev;
        if (lst)
        begin
            sample_pos = '0;
            seg_open   = 1'b0;
            seg_rising = 1'b0;
        end
        else if (sample_pos != POS_TOP)
            sample_pos++;
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns: %s mismatch, got %0h, want %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_field(input string what, input logic [15:0] got, input logic [15:0] want);
        if (got !== want)
            report_mismatch(what, 64'(got), 64'(want));
    endtask

    always @(posedge clk)
    begin : check_peaks
        wps_peak_t want_pk;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_peaks.size() == 0)
                report_mismatch("unexpected peak", m_tdata, 64'h0);
            else
            begin
                want_pk = pending_peaks.pop_front();
                check_field("peak_start", m_tdata[15:0], want_pk.start);
                check_field("peak_stop", m_tdata[31:16], want_pk.stop);
                check_field("peak_height", m_tdata[47:32], want_pk.height);
                check_field("peak_max_pos", m_tdata[63:48], want_pk.max_pos);
                check_field("peak_polarity", {15'h0, m_tuser}, {15'h0, want_pk.negative});
            end
        end
    end

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    // End the run once nothing has been accepted for too long
    initial
    begin : watchdog
        int idle_run;
        idle_run = 0;
        while (idle_run < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                idle_run = 0;
            else
                idle_run++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    task automatic send_sample(input logic [15:0] smp, input logic lst);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tlast  <= lst;
        do
            @(posedge clk);
        while (!s_tready);
        predict_peak(smp, lst);
        samples_sent++;
        @(negedge clk);
    endtask

    task automatic send_deviation(input int dev, input logic lst);
        int v;
        v = int'(cfg_baseline) + dev;
        if (v > 32767)
            v = 32767;
        else if (v < -32768)
            v = -32768;
        send_sample(v[15:0], lst);
    endtask

    task automatic send_wave(input int shape[$]);
        foreach (shape[i])
            send_deviation(shape[i], i == shape.size() - 1);
    endtask

    // Hold the sender until every peak is out and the pipeline has drained
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending_peaks.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input wps_reg_t idx, input logic [15:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0000, val};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        if (idx == REG_BASELINE)
            cfg_baseline = val;
        else
            cfg_threshold = val;
    endtask

    task automatic set_config(input logic [15:0] base, input logic [15:0] thr);
        wait_idle();
        write_reg(REG_BASELINE, base);
        write_reg(REG_THRESHOLD, thr);
    endtask

    task automatic test_directed_peaks();
        int wave[$];
        set_config(16'd0, 16'd10);
        // positive peak with a tied maximum, closed by a noise sample
        wave = {0, 0, 0, 20, 30, 40, 50, 50, 30, 5, 0};
        send_wave(wave);
        // negative peak at full scale, closed by a zero crossing, then ended by the last word
        wave = {0, 0, 0, -100, -200, -32768, 32767, 32767};
        send_wave(wave);
        // waveform too short for any segment
        wave = {5, 7};
        send_wave(wave);
    endtask

    task automatic test_random_waveforms(input int base, input int thr, input int count);
        int shape[$];
        int stop_at;
        int amp;
        int sgn;
        int rise;
        int fall;
        set_config(16'(base), 16'(thr));
        stop_at = samples_sent + count;
        while (samples_sent < stop_at)
        begin
            shape = {};
            if ($urandom_range(99) < 20)
            begin
                // raw samples over the full range
                repeat ($urandom_range(1, 30))
                    shape = {shape, int'($urandom_range(0, 65535)) - 32768 - int'(cfg_baseline)};
            end
            else
            begin
                repeat ($urandom_range(0, 5)) shape = {shape, noise_dev()};
                repeat ($urandom_range(1, 3))
                begin
                    amp = thr + int'($urandom_range(1, 3000));
                    if ($urandom_range(3) == 0)
                        amp = thr + int'($urandom_range(1, 65535));
                    sgn  = $urandom_range(1) ? -1 : 1;
                    rise = $urandom_range(1, 6);
                    for (int i = 1; i <= rise; i++)
                        shape = {shape, sgn * amp * i / rise};
                    // flip polarity now and then to force a zero crossing
                    if ($urandom_range(9) == 0)
                        sgn = -sgn;
                    fall = $urandom_range(1, 5);
                    for (int i = fall - 1; i >= 0; i--)
                        shape = {shape, sgn * amp * i / fall};
                    repeat ($urandom_range(0, 4)) shape = {shape, noise_dev()};
                end
            end
            send_wave(shape);
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 22;
        recv_idle_pct = 64;
        test_directed_peaks();
        test_random_waveforms(0, 100, 170);
        test_random_waveforms(-32768, 1000, 170);

        send_idle_pct = 64;
        recv_idle_pct = 22;
        test_random_waveforms(32767, 0, 170);
        test_random_waveforms(-1234, 5000, 170);
        test_random_waveforms(-32768, 65535, 100);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_waveforms(0, 0, 170);
        test_random_waveforms(300, 200, 100);

        wait_idle();
        if (mismatch_count == 0 && pending_peaks.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
